/* src/hll_pkg.sv */
package hll_pkg;

  localparam int UW   = 31;  // unsigned fields
  localparam int SW   = 32;  // signed fields
  localparam int FRAC = 16;

  localparam int RAD_W     = 48;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQ_STAGES = ROOT_W;

  localparam int MUL_W  = 64;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIV_QW = 33;
  localparam int DEN_W  = 64;

  // wave speed differences and the c1/c2 terms
  localparam int AW = 35;
  localparam int CW = 50;

  localparam int LAT       = 108;
  localparam int ITEM_TAPS = 69;

  typedef struct packed {
    logic [UW-1:0]        rl;
    logic [UW-1:0]        pl;
    logic signed [SW-1:0] vl;
    logic [UW-1:0]        cl;
    logic [UW-1:0]        rr;
    logic [UW-1:0]        pr;
    logic signed [SW-1:0] vr;
    logic [UW-1:0]        cr;
  } item_t;

  function automatic logic [MUL_W-1:0] mag_w(input logic signed [MUL_W-1:0] x);
    mag_w = x[MUL_W-1] ? MUL_W'(-x) : MUL_W'(x);
  endfunction

  function automatic logic [PROD_W-1:0] mag_p(input logic signed [PROD_W-1:0] x);
    mag_p = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
  endfunction

endpackage

/* src/hll_in_if.sv */
interface hll_in_if;
  import hll_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [UW-1:0]        left_density;
  logic [UW-1:0]        left_pressure;
  logic signed [SW-1:0] left_velocity;
  logic [UW-1:0]        left_speed;
  logic [UW-1:0]        right_density;
  logic [UW-1:0]        right_pressure;
  logic signed [SW-1:0] right_velocity;
  logic [UW-1:0]        right_speed;

  modport source (
    output valid, left_density, left_pressure, left_velocity, left_speed,
    output right_density, right_pressure, right_velocity, right_speed,
    input  ready
  );
  modport sink (
    input  valid, left_density, left_pressure, left_velocity, left_speed,
    input  right_density, right_pressure, right_velocity, right_speed,
    output ready
  );
endinterface

/* src/hll_out_if.sv */
interface hll_out_if;
  import hll_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [UW-1:0]        star_pressure;
  logic signed [SW-1:0] star_velocity;

  modport source (output valid, star_pressure, star_velocity, input ready);
  modport sink (input valid, star_pressure, star_velocity, output ready);
endinterface

/* src/hll_sqrt.sv */
module hll_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [hll_pkg::RAD_W-1:0]    x,
  output logic [hll_pkg::ROOT_W-1:0]   root
);
  import hll_pkg::*;

  logic [RAD_W-1:0] rem_q [SQ_STAGES];
  logic [RAD_W-1:0] res_q [SQ_STAGES];
  logic [RAD_W-1:0] rem_next [SQ_STAGES];
  logic [RAD_W-1:0] res_next [SQ_STAGES];

  // one result bit per stage
  always_comb begin
    logic [RAD_W-1:0] r_in, s_in, bitv, trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        r_in = x;
        s_in = '0;
      end else begin
        r_in = rem_q[k-1];
        s_in = res_q[k-1];
      end
      bitv  = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      trial = s_in + bitv;
      if (r_in >= trial) begin
        rem_next[k] = r_in - trial;
        res_next[k] = (s_in >> 1) + bitv;
      end else begin
        rem_next[k] = r_in;
        res_next[k] = s_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_q[k] <= rem_next[k];
        res_q[k] <= res_next[k];
      end
    end
  end

  assign root = res_q[SQ_STAGES-1][ROOT_W-1:0];
endmodule

/* src/hll_mul.sv */
module hll_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic [hll_pkg::MUL_W-1:0]          a,
  input  logic [hll_pkg::MUL_W-1:0]          b,
  input  logic                               neg,
  output logic signed [hll_pkg::PROD_W-1:0]  p
);
  import hll_pkg::*;
  localparam int HW = MUL_W / 2;

  logic [MUL_W-1:0]  pp_ll, pp_lh, pp_hl, pp_hh;
  logic              neg_q;
  logic [PROD_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= MUL_W'(a[HW-1:0] * b[HW-1:0]);
      pp_lh <= MUL_W'(a[HW-1:0] * b[MUL_W-1:HW]);
      pp_hl <= MUL_W'(a[MUL_W-1:HW] * b[HW-1:0]);
      pp_hh <= MUL_W'(a[MUL_W-1:HW] * b[MUL_W-1:HW]);
      neg_q <= neg;
    end
  end

  assign sum = {pp_hh, pp_ll}
             + {{HW{1'b0}}, pp_lh, {HW{1'b0}}}
             + {{HW{1'b0}}, pp_hl, {HW{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg_q ? PROD_W'(-sum) : sum;
    end
  end
endmodule

/* src/hll_div.sv */
module hll_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hll_pkg::PROD_W-1:0]    num,
  input  logic [hll_pkg::DEN_W-1:0]     den,
  input  logic                          neg,
  output logic [hll_pkg::DIV_QW-1:0]    quo,
  output logic                          ovf,
  output logic                          neg_out
);
  import hll_pkg::*;

  logic [DEN_W-1:0]  rem0;
  logic [DIV_QW-1:0] low0;
  logic [DEN_W-1:0]  d0;
  logic              ovf0, neg0;

  logic [DEN_W-1:0]  rem_q [DIV_QW];
  logic [DIV_QW-1:0] low_q [DIV_QW];
  logic [DIV_QW-1:0] quo_q [DIV_QW];
  logic [DEN_W-1:0]  d_q   [DIV_QW];
  logic              ovf_q [DIV_QW];
  logic              neg_q [DIV_QW];

  logic [DEN_W-1:0]  rem_next [DIV_QW];
  logic [DIV_QW-1:0] quo_next [DIV_QW];

  // quotient of 2^DIV_QW or more only raises the overflow flag
  always_ff @(posedge clk) begin
    if (en) begin
      ovf0 <= num[PROD_W-1:DIV_QW] >= (PROD_W - DIV_QW)'(den);
      rem0 <= num[DEN_W+DIV_QW-1:DIV_QW];
      low0 <= num[DIV_QW-1:0];
      d0   <= den;
      neg0 <= neg;
    end
  end

  always_comb begin
    logic [DEN_W-1:0]  r_in, d_in;
    logic [DIV_QW-1:0] l_in, q_in;
    logic [DEN_W:0]    t;
    for (int k = 0; k < DIV_QW; k++) begin
      if (k == 0) begin
        r_in = rem0;
        l_in = low0;
        q_in = '0;
        d_in = d0;
      end else begin
        r_in = rem_q[k-1];
        l_in = low_q[k-1];
        q_in = quo_q[k-1];
        d_in = d_q[k-1];
      end
      t = {r_in, l_in[DIV_QW-1]};
      if (t >= {1'b0, d_in}) begin
        rem_next[k] = DEN_W'(t - {1'b0, d_in});
        quo_next[k] = {q_in[DIV_QW-2:0], 1'b1};
      end else begin
        rem_next[k] = t[DEN_W-1:0];
        quo_next[k] = {q_in[DIV_QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_QW; k++) begin
        rem_q[k] <= rem_next[k];
        quo_q[k] <= quo_next[k];
        if (k == 0) begin
          low_q[k] <= low0 << 1;
          d_q[k]   <= d0;
          ovf_q[k] <= ovf0;
          neg_q[k] <= neg0;
        end else begin
          low_q[k] <= low_q[k-1] << 1;
          d_q[k]   <= d_q[k-1];
          ovf_q[k] <= ovf_q[k-1];
          neg_q[k] <= neg_q[k-1];
        end
      end
    end
  end

  assign quo     = quo_q[DIV_QW-1];
  assign ovf     = ovf_q[DIV_QW-1];
  assign neg_out = neg_q[DIV_QW-1];
endmodule

/* src/hll_interface_state_solver.sv */
// Throughput: one transaction per cycle while not stalled; the square root (24
// stages, one bit per stage) and the restoring dividers (34 stages, an overflow
// stage and then one quotient bit per stage) are fully pipelined.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous) clears all stage valid bits; payload is not reset.
module hll_interface_state_solver (
  input  logic        clk,
  input  logic        rst,
  hll_in_if.sink      pair,
  hll_out_if.source   star
);
  import hll_pkg::*;

  localparam logic [DIV_QW-1:0] Q_SMIN_MAG = DIV_QW'(1) << (SW - 1);
  localparam logic [DIV_QW-1:0] Q_SMAX     = Q_SMIN_MAG - DIV_QW'(1);
  localparam logic [DIV_QW-1:0] Q_UMAX     = (DIV_QW'(1) << UW) - DIV_QW'(1);

  function automatic logic [RAD_W-1:0] radicand(input logic [UW-1:0] rho);
    radicand = (rho == '0) ? (RAD_W'(1) << FRAC) : (RAD_W'(rho) << FRAC);
  endfunction

  logic           en;
  logic [LAT-1:0] vld;
  item_t          tap [ITEM_TAPS];

  assign en         = !vld[LAT-1] || star.ready;
  assign pair.ready = en;
  assign star.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pair.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= '{rl: pair.left_density,  pl: pair.left_pressure,
                  vl: pair.left_velocity, cl: pair.left_speed,
                  rr: pair.right_density, pr: pair.right_pressure,
                  vr: pair.right_velocity, cr: pair.right_speed};
      for (int k = 1; k < ITEM_TAPS; k++) begin
        tap[k] <= tap[k-1];
      end
    end
  end

  // Roe weights
  logic [ROOT_W-1:0] gl, gr;

  hll_sqrt u_sqrt_l (.clk(clk), .en(en), .x(radicand(tap[0].rl)), .root(gl));
  hll_sqrt u_sqrt_r (.clk(clk), .en(en), .x(radicand(tap[0].rr)), .root(gr));

  logic signed [PROD_W-1:0] pu_l, pu_r, pc_l, pc_r;

  hll_mul u_mul_ul (.clk(clk), .en(en), .a(MUL_W'(gl)),
                    .b(mag_w(MUL_W'(tap[24].vl))), .neg(tap[24].vl[SW-1]), .p(pu_l));
  hll_mul u_mul_ur (.clk(clk), .en(en), .a(MUL_W'(gr)),
                    .b(mag_w(MUL_W'(tap[24].vr))), .neg(tap[24].vr[SW-1]), .p(pu_r));
  hll_mul u_mul_cl (.clk(clk), .en(en), .a(MUL_W'(gl)),
                    .b(MUL_W'(tap[24].cl)), .neg(1'b0), .p(pc_l));
  hll_mul u_mul_cr (.clk(clk), .en(en), .a(MUL_W'(gr)),
                    .b(MUL_W'(tap[24].cr)), .neg(1'b0), .p(pc_r));

  logic [ROOT_W:0]          gs1, gs2, gs3;
  logic signed [PROD_W-1:0] unum, cnum;

  always_ff @(posedge clk) begin
    if (en) begin
      gs1  <= (ROOT_W+1)'(gl) + (ROOT_W+1)'(gr);
      gs2  <= gs1;
      gs3  <= gs2;
      unum <= pu_l + pu_r;
      cnum <= pc_l + pc_r;
    end
  end

  logic [DIV_QW-1:0] uq, cq;
  logic              uneg;

  hll_div u_div_u (.clk(clk), .en(en), .num(mag_p(unum)), .den(DEN_W'(gs3)),
                   .neg(unum[PROD_W-1]), .quo(uq), .ovf(), .neg_out(uneg));
  hll_div u_div_c (.clk(clk), .en(en), .num(PROD_W'(cnum)), .den(DEN_W'(gs3)),
                   .neg(1'b0), .quo(cq), .ovf(), .neg_out());

  // Einfeldt wave speeds
  logic signed [AW-1:0] ut, ct;
  logic signed [AW-1:0] d1, d2, d1_next, d2_next;

  always_ff @(posedge clk) begin
    if (en) begin
      ut <= uneg ? AW'(-AW'(uq)) : AW'(uq);
      ct <= AW'(cq);
      d1 <= d1_next;
      d2 <= d2_next;
    end
  end

  always_comb begin
    logic signed [AW-1:0] vl_x, vr_x, cl_x, cr_x, a1, a2, b1, b2, sl, sr;
    vl_x = AW'(tap[62].vl);
    vr_x = AW'(tap[62].vr);
    cl_x = {{(AW-UW){1'b0}}, tap[62].cl};
    cr_x = {{(AW-UW){1'b0}}, tap[62].cr};
    a1 = vl_x - cl_x;
    a2 = ut - ct;
    b1 = vr_x + cr_x;
    b2 = ut + ct;
    sl = (a1 < a2) ? a1 : a2;
    sr = (b1 > b2) ? b1 : b2;
    d1_next = sl - vl_x;
    d2_next = sr - vr_x;
  end

  logic signed [PROD_W-1:0] q1p, q2p;

  hll_mul u_mul_c1 (.clk(clk), .en(en), .a(MUL_W'(tap[63].rl)),
                    .b(mag_w(MUL_W'(d1))), .neg(d1[AW-1]), .p(q1p));
  hll_mul u_mul_c2 (.clk(clk), .en(en), .a(MUL_W'(tap[63].rr)),
                    .b(mag_w(MUL_W'(d2))), .neg(d2[AW-1]), .p(q2p));

  logic signed [CW-1:0] c1, c2, c1_a, c2_a, c1_b, c2_b, c1c, c2c;

  always_ff @(posedge clk) begin
    if (en) begin
      c1   <= q1p[FRAC+CW-1:FRAC];
      c2   <= q2p[FRAC+CW-1:FRAC];
      c1_a <= c1;
      c2_a <= c2;
      c1_b <= c1_a;
      c2_b <= c2_a;
    end
  end

  logic signed [PROD_W-1:0] m3l, m3r;

  hll_mul u_mul_4 (.clk(clk), .en(en), .a(mag_w(MUL_W'(c1))),
                   .b(mag_w(MUL_W'(tap[66].vl))), .neg(c1[CW-1] ^ tap[66].vl[SW-1]),
                   .p(m3l));
  hll_mul u_mul_5 (.clk(clk), .en(en), .a(mag_w(MUL_W'(c2))),
                   .b(mag_w(MUL_W'(tap[66].vr))), .neg(c2[CW-1] ^ tap[66].vr[SW-1]),
                   .p(m3r));

  logic signed [MUL_W-1:0] c4, c5;
  logic signed [CW:0]      den70, den71, den72;

  always_ff @(posedge clk) begin
    if (en) begin
      c4    <= $signed(MUL_W'(tap[68].pl)) - $signed(m3l[FRAC+MUL_W-1:FRAC]);
      c5    <= $signed(MUL_W'(tap[68].pr)) - $signed(m3r[FRAC+MUL_W-1:FRAC]);
      c1c   <= c1_b;
      c2c   <= c2_b;
      den70 <= (CW+1)'(c1_b) - (CW+1)'(c2_b);
      den71 <= den70;
      den72 <= den71;
    end
  end

  logic signed [PROD_W-1:0] m4a, m4b;

  hll_mul u_mul_6 (.clk(clk), .en(en), .a(mag_w(MUL_W'(c1c))), .b(mag_w(c5)),
                   .neg(c1c[CW-1] ^ c5[MUL_W-1]), .p(m4a));
  hll_mul u_mul_7 (.clk(clk), .en(en), .a(mag_w(MUL_W'(c2c))), .b(mag_w(c4)),
                   .neg(c2c[CW-1] ^ c4[MUL_W-1]), .p(m4b));

  logic signed [MUL_W:0]   diff;
  logic signed [MUL_W-1:0] vd71, vd72;

  assign diff = (MUL_W+1)'(c5) - (MUL_W+1)'(c4);

  always_ff @(posedge clk) begin
    if (en) begin
      if (diff[MUL_W] != diff[MUL_W-1]) begin
        vd71 <= diff[MUL_W] ? {1'b1, {(MUL_W-1){1'b0}}} : {1'b0, {(MUL_W-1){1'b1}}};
      end else begin
        vd71 <= diff[MUL_W-1:0];
      end
      vd72 <= vd71;
    end
  end

  // numerators and denominator as magnitude and sign for the dividers
  logic signed [PROD_W-1:0]      pnum;
  logic signed [CW:0]            den_fix, den_mag;
  logic signed [MUL_W+FRAC-1:0]  vnum;
  logic [PROD_W-1:0]             pmag;
  logic [MUL_W+FRAC-1:0]         vmag;
  logic [DEN_W-1:0]              dmag;
  logic                          pneg, vneg;

  always_comb begin
    pnum    = m4a - m4b;
    den_fix = (den72 == '0) ? (CW+1)'(1) : den72;
    den_mag = den_fix[CW] ? -den_fix : den_fix;
    vnum    = {vd72, {FRAC{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmag <= mag_p(pnum);
      pneg <= pnum[PROD_W-1] ^ den_fix[CW];
      vmag <= vnum[MUL_W+FRAC-1] ? (MUL_W+FRAC)'(-vnum) : (MUL_W+FRAC)'(vnum);
      vneg <= vd72[MUL_W-1] ^ den_fix[CW];
      dmag <= DEN_W'(unsigned'(den_mag));
    end
  end

  logic [DIV_QW-1:0] pq, vq;
  logic              povf, vovf, pneg_o, vneg_o;

  hll_div u_div_p (.clk(clk), .en(en), .num(pmag), .den(dmag), .neg(pneg),
                   .quo(pq), .ovf(povf), .neg_out(pneg_o));
  hll_div u_div_v (.clk(clk), .en(en), .num(PROD_W'(vmag)), .den(dmag), .neg(vneg),
                   .quo(vq), .ovf(vovf), .neg_out(vneg_o));

  logic [UW-1:0]        sp, sp_next;
  logic signed [SW-1:0] sv, sv_next;

  always_comb begin
    if (pneg_o || (!povf && pq == '0)) begin
      sp_next = UW'(1);
    end else if (povf || pq > Q_UMAX) begin
      sp_next = Q_UMAX[UW-1:0];
    end else begin
      sp_next = pq[UW-1:0];
    end

    if (vneg_o) begin
      if (vovf || vq > Q_SMIN_MAG) begin
        sv_next = {1'b1, {(SW-1){1'b0}}};
      end else begin
        sv_next = -$signed(vq[SW-1:0]);
      end
    end else if (vovf || vq > Q_SMAX) begin
      sv_next = {1'b0, {(SW-1){1'b1}}};
    end else begin
      sv_next = vq[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp <= sp_next;
      sv <= sv_next;
    end
  end

  assign star.star_pressure = sp;
  assign star.star_velocity = sv;
endmodule

/* src/hll_checker.sv */
module hll_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_ready,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [hll_pkg::UW-1:0]   star_pressure
);
  import hll_pkg::*;

  // no result leaves the pipeline right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // an empty output register never blocks the input
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> star_pressure != '0)
    else $error("star pressure below one LSB");

  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("result transaction dropped while stalled");
endmodule

bind hll_interface_state_solver hll_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(pair.ready),
  .out_valid(star.valid),
  .out_ready(star.ready),
  .star_pressure(star.star_pressure)
);
